// File: rtl/s3tc_block_decoder_defines.svh
// ---------------------------------------------------------------------------
// S3TC block decoder assertion macros
// Shared concurrent assertion forms, clocked on a rising edge and disabled
// while the active-low reset is asserted.
// ---------------------------------------------------------------------------
`ifndef S3TC_BLOCK_DECODER_DEFINES_SVH
`define S3TC_BLOCK_DECODER_DEFINES_SVH

// Property holds at every edge out of reset.
`define S3TC_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("%m: assertion failed");

// Antecedent in this cycle implies consequent in the next one.
`define S3TC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m: assertion failed");

`endif

// File: rtl/s3tc_pkg.sv
// ---------------------------------------------------------------------------
// S3TC block decoder package
// Block descriptor passed from the palette front end to the pixel back end,
// format codes and the front-end state type.
// ---------------------------------------------------------------------------
package s3tc_pkg;

  // format_mode codes
  localparam logic [1:0] MODE_DXT1  = 2'd0;
  localparam logic [1:0] MODE_PUNCH = 2'd1;
  localparam logic [1:0] MODE_DXT3  = 2'd2;
  localparam logic [1:0] MODE_DXT5  = 2'd3;

  // block descriptors held between front and back end
  localparam int unsigned QUEUE_DEPTH = 2;

  // decoded block: colour palette [entry][R,G,B], alpha palette, raw indices
  typedef struct packed {
    logic [3:0][2:0][7:0] pal;
    logic [7:0][7:0]      apal;
    logic                 three;
    logic [31:0]          cidx;
    logic [63:0]          aword;
  } blk_t;

  typedef enum logic [1:0] {
    FR_IDLE,
    FR_CALC,
    FR_PUSH
  } fr_state_e;

endpackage

// File: rtl/s3tc_front.sv
// ---------------------------------------------------------------------------
// S3TC palette front end
// Takes a block word, widens the endpoints and builds the interpolated color
// and alpha palettes one value a cycle through a shared constant divider.
// ---------------------------------------------------------------------------
module s3tc_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [1:0]          mode_i,
  input  logic                start,
  output logic                busy,
  input  logic [63:0]         alpha_word_i,
  input  logic [63:0]         color_word_i,
  output logic                push_valid_o,
  input  logic                push_ready_i,
  output s3tc_pkg::blk_t      push_data_o
);
  import s3tc_pkg::*;

  typedef enum logic [2:0] {
    DIV_1,
    DIV_2,
    DIV_3,
    DIV_5,
    DIV_7
  } div_e;

  localparam logic [3:0] LAST_STEP   = 4'd12; // steps 0..11 issue, 12 drains
  localparam logic [3:0] ALPHA_STEP  = 4'd6;
  localparam int unsigned RECIP_SHIFT = 16;

  function automatic logic [7:0] widen5(input logic [4:0] v);
    widen5 = {v, v[4:2]};
  endfunction

  function automatic logic [7:0] widen6(input logic [5:0] v);
    widen6 = {v, v[5:4]};
  endfunction

  // ceil(2^16 / d); exact for every numerator this unit sees
  function automatic logic [16:0] recip(input div_e d);
    case (d)
      DIV_1:   recip = 17'd65536;
      DIV_2:   recip = 17'd32768;
      DIV_3:   recip = 17'd21846;
      DIV_5:   recip = 17'd13108;
      DIV_7:   recip = 17'd9363;
      default: recip = 17'd65536;
    endcase
  endfunction

  // color steps 0..5: entry 2 for R,G,B then entry 3 for R,G,B
  function automatic logic [1:0] step_chan(input logic [3:0] s);
    if (s >= 4'd3) begin
      step_chan = 2'(s - 4'd3);
    end else begin
      step_chan = 2'(s);
    end
  endfunction

  fr_state_e   state_q, state_d;
  logic [3:0]  step_q, step_d;
  logic        a_vld_q, a_vld_d;
  logic [10:0] num_q, num_d;
  div_e        div_q, div_d;
  logic [3:0]  dst_q;
  blk_t        blk_q, blk_d;

  logic        load;
  logic [1:0]  ch, dst_ch;
  logic        e3;
  logic [7:0]  p0, p1, a0, a1;
  logic [2:0]  wi;
  logic [27:0] prod;
  logic [7:0]  quot;
  logic [15:0] ep0, ep1;

  assign ep0 = color_word_i[15:0];
  assign ep1 = color_word_i[31:16];

  // FSM
  always_comb begin
    state_d      = state_q;
    step_d       = step_q;
    a_vld_d      = 1'b0;
    load         = 1'b0;
    push_valid_o = 1'b0;
    busy         = 1'b1;
    case (state_q)
      FR_IDLE: begin
        busy = 1'b0;
        if (start) begin
          load    = 1'b1;
          step_d  = '0;
          state_d = FR_CALC;
        end
      end
      FR_CALC: begin
        a_vld_d = (step_q != LAST_STEP);
        step_d  = step_q + 4'd1;
        if (step_q == LAST_STEP) begin
          state_d = FR_PUSH;
        end
      end
      FR_PUSH: begin
        push_valid_o = 1'b1;
        if (push_ready_i) begin
          busy = 1'b0;
          if (start) begin
            load    = 1'b1;
            step_d  = '0;
            state_d = FR_CALC;
          end else begin
            state_d = FR_IDLE;
          end
        end
      end
      default: begin
        state_d = FR_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= FR_IDLE;
      step_q  <= '0;
      a_vld_q <= 1'b0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      a_vld_q <= a_vld_d;
    end
  end

  // issue stage: numerator and divisor of the current step
  assign ch = step_chan(step_q);
  assign e3 = (step_q >= 4'd3);
  assign p0 = blk_q.pal[0][ch];
  assign p1 = blk_q.pal[1][ch];
  assign a0 = blk_q.apal[0];
  assign a1 = blk_q.apal[1];
  assign wi = 3'(step_q - 4'd5);

  always_comb begin
    num_d = '0;
    div_d = DIV_1;
    if (step_q < ALPHA_STEP) begin
      if (!blk_q.three) begin
        num_d = e3 ? (11'(p0) + {2'b00, p1, 1'b0}) : ({2'b00, p0, 1'b0} + 11'(p1));
        div_d = DIV_3;
      end else if (!e3) begin
        num_d = 11'(p0) + 11'(p1);
        div_d = DIV_2;
      end else begin
        num_d = '0;                       // black
        div_d = DIV_1;
      end
    end else if (a0 > a1) begin
      num_d = 11'(3'd7 - wi) * 11'(a0) + 11'(wi) * 11'(a1);
      div_d = DIV_7;
    end else if (wi <= 3'd4) begin
      num_d = 11'(3'd5 - wi) * 11'(a0) + 11'(wi) * 11'(a1);
      div_d = DIV_5;
    end else if (wi == 3'd5) begin
      num_d = '0;
      div_d = DIV_1;
    end else begin
      num_d = 11'd255;
      div_d = DIV_1;
    end
  end

  // divide stage: multiply by reciprocal, write palette entry
  assign prod   = 28'(num_q) * 28'(recip(div_q));
  assign quot   = prod[RECIP_SHIFT +: 8];
  assign dst_ch = step_chan(dst_q);

  always_comb begin
    blk_d = blk_q;
    if (load) begin
      blk_d.pal[0][0] = widen5(ep0[15:11]);
      blk_d.pal[0][1] = widen6(ep0[10:5]);
      blk_d.pal[0][2] = widen5(ep0[4:0]);
      blk_d.pal[1][0] = widen5(ep1[15:11]);
      blk_d.pal[1][1] = widen6(ep1[10:5]);
      blk_d.pal[1][2] = widen5(ep1[4:0]);
      blk_d.pal[2]    = '0;
      blk_d.pal[3]    = '0;
      blk_d.apal      = '0;
      blk_d.apal[0]   = alpha_word_i[7:0];
      blk_d.apal[1]   = alpha_word_i[15:8];
      blk_d.three     = (mode_i == MODE_DXT1 || mode_i == MODE_PUNCH) && (ep0 <= ep1);
      blk_d.cidx      = color_word_i[63:32];
      blk_d.aword     = alpha_word_i;
    end else if (a_vld_q) begin
      if (dst_q < ALPHA_STEP) begin
        blk_d.pal[{1'b1, (dst_q >= 4'd3)}][dst_ch] = quot;
      end else begin
        blk_d.apal[3'(dst_q - 4'd4)] = quot;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    blk_q <= blk_d;
    num_q <= num_d;
    div_q <= div_d;
    dst_q <= step_q;
  end

  assign push_data_o = blk_q;

endmodule

// File: rtl/s3tc_queue.sv
// ---------------------------------------------------------------------------
// S3TC block queue
// Small FIFO of decoded block descriptors between front and back end.
// ---------------------------------------------------------------------------
`include "s3tc_block_decoder_defines.svh"

module s3tc_queue #(
  parameter int unsigned DEPTH = s3tc_pkg::QUEUE_DEPTH
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_valid_i,
  output logic           push_ready_o,
  input  s3tc_pkg::blk_t push_data_i,
  output logic           pop_valid_o,
  input  logic           pop_i,
  output s3tc_pkg::blk_t pop_data_o
);
  import s3tc_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  blk_t             mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] count_q;
  logic             push, pop;

  assign push_ready_o = (count_q != CNT_FULL);
  assign pop_valid_o  = (count_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_i && pop_valid_o;
  assign pop_data_o   = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + PTR_W'(1);
      end
      count_q <= count_q + CNT_W'(push) - CNT_W'(pop);
    end
  end

  `S3TC_ASSERT(a_cnt_bound, clk_i, rst_ni, count_q <= CNT_FULL)
  `S3TC_ASSERT_NEXT(a_full_hold, clk_i, rst_ni, !push_ready_o && !pop_i, !push_ready_o)

endmodule

// File: rtl/s3tc_back.sv
// ---------------------------------------------------------------------------
// S3TC pixel back end
// Walks the sixteen pixels of the head block and registers one RGBA pixel
// a cycle while the queue presents a head block.
// ---------------------------------------------------------------------------
`include "s3tc_block_decoder_defines.svh"

module s3tc_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic [1:0]     mode_i,
  input  logic           head_valid_i,
  input  s3tc_pkg::blk_t head_i,
  output logic           pop_o,
  output logic           result_valid_o,
  output logic [7:0]     red_o,
  output logic [7:0]     green_o,
  output logic [7:0]     blue_o,
  output logic [7:0]     alpha_o,
  output logic [3:0]     pixel_index_o,
  output logic           last_pixel_o
);
  import s3tc_pkg::*;

  localparam logic [3:0] PIX_LAST = 4'd15;

  logic [3:0] pix_q;
  logic       vld_q;
  logic [1:0] ci;
  logic [5:0] abit;
  logic [3:0] nib;
  logic [7:0] alpha_d;
  logic [7:0] red_q, green_q, blue_q, alpha_q;
  logic [3:0] idx_q;
  logic       last_q;

  assign ci    = head_i.cidx[{pix_q, 1'b0} +: 2];
  assign nib   = head_i.aword[{pix_q, 2'b00} +: 4];
  assign abit  = 6'd16 + 6'({pix_q, 1'b0}) + 6'(pix_q);
  assign pop_o = head_valid_i && (pix_q == PIX_LAST);

  always_comb begin
    case (mode_i)
      MODE_DXT3:  alpha_d = {nib, nib};                       // times 17
      MODE_DXT5:  alpha_d = head_i.apal[head_i.aword[abit +: 3]];
      MODE_PUNCH: alpha_d = (head_i.three && ci == 2'd3) ? 8'd0 : 8'd255;
      default:    alpha_d = 8'd255;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pix_q <= '0;
      vld_q <= 1'b0;
    end else begin
      vld_q <= head_valid_i;
      if (head_valid_i) begin
        pix_q <= pix_q + 4'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    red_q   <= head_i.pal[ci][0];
    green_q <= head_i.pal[ci][1];
    blue_q  <= head_i.pal[ci][2];
    alpha_q <= alpha_d;
    idx_q   <= pix_q;
    last_q  <= (pix_q == PIX_LAST);
  end

  assign result_valid_o = vld_q;
  assign red_o          = red_q;
  assign green_o        = green_q;
  assign blue_o         = blue_q;
  assign alpha_o        = alpha_q;
  assign pixel_index_o  = idx_q;
  assign last_pixel_o   = last_q;

  `S3TC_ASSERT_NEXT(a_burst, clk_i, rst_ni, vld_q && !last_q, vld_q)
  `S3TC_ASSERT_NEXT(a_order, clk_i, rst_ni, vld_q && !last_q, idx_q == $past(idx_q) + 4'd1)

endmodule

// File: rtl/s3tc_block_decoder.sv
// ---------------------------------------------------------------------------
// S3TC block decoder
// Decodes DXT1 / DXT3 / DXT5 4x4 blocks into sixteen RGBA8 pixels each.
// ---------------------------------------------------------------------------
// Usage:
//   Input word: alpha_word_i and color_word_i are taken at a rising edge with
//   start high and busy low. busy stays high while the front end builds the
//   palettes (one color channel or alpha entry per cycle through a shared
//   reciprocal-multiply divider) and while the block queue is full.
//   Results: sixteen pixels per block, row-major, one per cycle, each marked
//   by result_valid_o for one cycle; last_pixel_o flags pixel 15. The
//   receiver cannot stall, so the back end never waits.
//   First pixel: palette steps in FR_CALC, push into the queue, back-end output register.
//   Throughput: set by the back end, which emits one pixel per cycle while a
//   block is queued; the front end works on the next block meanwhile.
//   Config: format_mode at APB address 0 (0 DXT1, 1 DXT1 punch-through,
//   2 DXT3, 3 DXT5); write it only while idle. pready is tied high.
//   Reset: rst_ni clears the queue, the sequencers and format_mode (DXT1).
// ---------------------------------------------------------------------------
module s3tc_block_decoder #(
  parameter int unsigned QueueDepth = s3tc_pkg::QUEUE_DEPTH
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // block input
  input  logic        start,
  output logic        busy,
  input  logic [63:0] alpha_word_i,
  input  logic [63:0] color_word_i,
  // pixel output
  output logic        result_valid_o,
  output logic [7:0]  red_o,
  output logic [7:0]  green_o,
  output logic [7:0]  blue_o,
  output logic [7:0]  alpha_o,
  output logic [3:0]  pixel_index_o,
  output logic        last_pixel_o,
  // config port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import s3tc_pkg::*;

  logic [1:0] mode_q;
  logic       cfg_wr;
  logic       push_valid, push_ready;
  blk_t       push_data;
  logic       head_valid, pop;
  blk_t       head;

  // format_mode register; word address 4 and up is unmapped
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && !paddr[2];
  assign prdata = paddr[2] ? 32'd0 : {30'd0, mode_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_DXT1;
    end else if (cfg_wr) begin
      mode_q <= pwdata[1:0];
    end
  end

  // front end: endpoint widening and palette build
  s3tc_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .mode_i       (mode_q),
    .start        (start),
    .busy         (busy),
    .alpha_word_i (alpha_word_i),
    .color_word_i (color_word_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_data_o  (push_data)
  );

  // decoded blocks waiting for the back end
  s3tc_queue #(
    .DEPTH (QueueDepth)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  (push_data),
    .pop_valid_o  (head_valid),
    .pop_i        (pop),
    .pop_data_o   (head)
  );

  // back end: per-pixel palette lookup, one pixel a cycle while a block is queued
  s3tc_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .mode_i         (mode_q),
    .head_valid_i   (head_valid),
    .head_i         (head),
    .pop_o          (pop),
    .result_valid_o (result_valid_o),
    .red_o          (red_o),
    .green_o        (green_o),
    .blue_o         (blue_o),
    .alpha_o        (alpha_o),
    .pixel_index_o  (pixel_index_o),
    .last_pixel_o   (last_pixel_o)
  );

endmodule
